>>> design/nfp_pkg.sv
package nfp_pkg;

  localparam int unsigned MaxFracDigits = 5;
  localparam int unsigned ValueBits     = 32;
  localparam int unsigned MaxFields     = 63;

  localparam int unsigned HdrLen = 5;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_CHC   = 2'd1,
    KIND_GGA   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_NUM  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_ABORT    = 2'd3
  } status_e;

  // byte classes decided by the front end
  typedef enum logic [2:0] {
    CL_DIGIT = 3'd0,
    CL_MINUS = 3'd1,
    CL_POINT = 3'd2,
    CL_COMMA = 3'd3,
    CL_STAR  = 3'd4,
    CL_ABORT = 3'd5,
    CL_OTHER = 3'd6,
    CL_START = 3'd7
  } class_e;

  typedef struct packed {
    class_e     cls;
    logic [7:0] ch;
  } token_t;

  function automatic logic [7:0] hdr_chc(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = 8'h47;
      3'd1:    r = 8'h50;
      3'd2:    r = 8'h43;
      3'd3:    r = 8'h48;
      3'd4:    r = 8'h43;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hdr_gga(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = 8'h47;
      3'd1:    r = 8'h50;
      3'd2:    r = 8'h47;
      3'd3:    r = 8'h47;
      3'd4:    r = 8'h41;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

>>> design/nfp_front.sv
module nfp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [7:0]    byte_i,
  output logic          valid_o,
  output nfp_pkg::token_t tok_o
);
  import nfp_pkg::*;

  logic   valid_q;
  token_t tok_q, tok_d;

  always_comb begin
    tok_d.ch = byte_i;
    if (byte_i == 8'h24) tok_d.cls = CL_START;
    else if (byte_i < 8'h20 || byte_i > 8'h7a) tok_d.cls = CL_ABORT;
    else if (byte_i >= 8'h30 && byte_i <= 8'h39) tok_d.cls = CL_DIGIT;
    else if (byte_i == 8'h2d) tok_d.cls = CL_MINUS;
    else if (byte_i == 8'h2e) tok_d.cls = CL_POINT;
    else if (byte_i == 8'h2c) tok_d.cls = CL_COMMA;
    else if (byte_i == 8'h2a) tok_d.cls = CL_STAR;
    else tok_d.cls = CL_OTHER;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;
endmodule

>>> design/nfp_back.sv
module nfp_back #(
  parameter int unsigned MAX_FRAC_DIGITS = nfp_pkg::MaxFracDigits,
  parameter int unsigned VALUE_BITS      = nfp_pkg::ValueBits,
  parameter int unsigned MAX_FIELDS      = nfp_pkg::MaxFields
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  nfp_pkg::token_t       tok_i,
  output logic                  res_valid_o,
  output logic [1:0]            sentence_kind_o,
  output logic [5:0]            field_index_o,
  output logic [VALUE_BITS-1:0] field_value_o,
  output logic [2:0]            frac_digits_o,
  output logic [7:0]            first_char_o,
  output logic [1:0]            field_status_o,
  output logic                  last_field_o
);
  import nfp_pkg::*;

  localparam int unsigned AccW = VALUE_BITS + 1;
  localparam int unsigned CntW = $clog2(MAX_FIELDS + 1);
  localparam int unsigned FrW  = $clog2(MAX_FRAC_DIGITS + 1);
  localparam logic [AccW-1:0] Lim = {1'b0, 1'b1, {(VALUE_BITS-1){1'b0}}};

  logic            in_sent_q, in_sent_d;
  logic [2:0]      hpos_q, hpos_d;
  logic [1:0]      hmatch_q, hmatch_d;
  logic [1:0]      kind_q, kind_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [FrW-1:0]  frac_q, frac_d;
  logic            sign_q, sign_d, point_q, point_d, bad_q, bad_d;
  logic            ovf_q, ovf_d, start_q, start_d;
  logic [7:0]      first_q, first_d;

  logic [AccW-1:0] bound, nxt, mag;
  logic [AccW+3:0] prod;
  logic [3:0]      dig;
  logic            emit, last;
  logic [1:0]      status;
  logic [AccW-1:0] val;

  assign bound = sign_q ? Lim : Lim - AccW'(1);
  assign dig   = tok_i.ch[3:0];
  assign prod  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + (AccW+4)'(dig);
  assign nxt   = prod[AccW-1:0];

  always_comb begin
    in_sent_d = in_sent_q; hpos_d = hpos_q; hmatch_d = hmatch_q; kind_d = kind_q;
    cnt_d = cnt_q; acc_d = acc_q; frac_d = frac_q; sign_d = sign_q;
    point_d = point_q; bad_d = bad_q; ovf_d = ovf_q; start_d = start_q;
    first_d = first_q;
    emit = 1'b0; last = 1'b0; status = ST_OK;
    if (valid_i) begin
      if (tok_i.cls == CL_START) begin
        in_sent_d = 1'b1; hpos_d = '0; hmatch_d = 2'b11; kind_d = KIND_OTHER;
        cnt_d = '0; acc_d = '0; frac_d = '0; sign_d = 1'b0; point_d = 1'b0;
        bad_d = 1'b0; ovf_d = 1'b0; start_d = 1'b0; first_d = '0;
      end else if (in_sent_q) begin
        if (tok_i.cls == CL_ABORT) begin
          in_sent_d = 1'b0;
          if (cnt_q != '0) begin
            emit = 1'b1; last = 1'b1; status = ST_ABORT;
          end
        end else if (cnt_q == '0) begin
          // address field
          if (tok_i.cls == CL_STAR) begin
            in_sent_d = 1'b0;
          end else if (tok_i.cls == CL_COMMA) begin
            if (hpos_q == 3'(HdrLen) && hmatch_q[0]) kind_d = KIND_CHC;
            else if (hpos_q == 3'(HdrLen) && hmatch_q[1]) kind_d = KIND_GGA;
            else kind_d = KIND_OTHER;
            cnt_d = CntW'(1);
            acc_d = '0; frac_d = '0; sign_d = 1'b0; point_d = 1'b0;
            bad_d = 1'b0; ovf_d = 1'b0; start_d = 1'b0; first_d = '0;
          end else if (hpos_q < 3'(HdrLen)) begin
            if (tok_i.ch != hdr_chc(hpos_q)) hmatch_d[0] = 1'b0;
            if (tok_i.ch != hdr_gga(hpos_q)) hmatch_d[1] = 1'b0;
            hpos_d = hpos_q + 3'd1;
          end else begin
            hmatch_d = 2'b00;
          end
        end else if (tok_i.cls == CL_COMMA || tok_i.cls == CL_STAR) begin
          emit = 1'b1;
          last = (tok_i.cls == CL_STAR);
          status = bad_q ? ST_NOT_NUM : (ovf_q ? ST_OVERFLOW : ST_OK);
          if (last) in_sent_d = 1'b0;
          else if (cnt_q < CntW'(MAX_FIELDS)) cnt_d = cnt_q + CntW'(1);
          acc_d = '0; frac_d = '0; sign_d = 1'b0; point_d = 1'b0;
          bad_d = 1'b0; ovf_d = 1'b0; start_d = 1'b0; first_d = '0;
        end else begin
          if (!start_q) begin
            first_d = tok_i.ch; start_d = 1'b1;
          end
          if (tok_i.cls == CL_MINUS && !start_q) begin
            sign_d = 1'b1;
          end else if (tok_i.cls == CL_POINT) begin
            if (point_q) bad_d = 1'b1;
            else point_d = 1'b1;
          end else if (tok_i.cls == CL_DIGIT) begin
            if (!bad_q && !ovf_q && !(point_q && frac_q >= FrW'(MAX_FRAC_DIGITS))) begin
              // acc*10+d > bound is the same test as acc > (bound-d)/10
              if (prod > (AccW+4)'(bound)) begin
                ovf_d = 1'b1;
              end else begin
                acc_d = nxt;
                if (point_q) frac_d = frac_q + FrW'(1);
              end
            end
          end else begin
            bad_d = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    case (status)
      ST_OK:       mag = acc_q;
      ST_OVERFLOW: mag = bound;
      default:     mag = '0;
    endcase
    val = sign_q ? (AccW'(0) - mag) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q <= 1'b0; hpos_q <= '0; hmatch_q <= 2'b11; kind_q <= KIND_OTHER;
      cnt_q <= '0; acc_q <= '0; frac_q <= '0; sign_q <= 1'b0; point_q <= 1'b0;
      bad_q <= 1'b0; ovf_q <= 1'b0; start_q <= 1'b0; first_q <= '0;
      res_valid_o <= 1'b0;
    end else begin
      in_sent_q <= in_sent_d; hpos_q <= hpos_d; hmatch_q <= hmatch_d; kind_q <= kind_d;
      cnt_q <= cnt_d; acc_q <= acc_d; frac_q <= frac_d; sign_q <= sign_d;
      point_q <= point_d; bad_q <= bad_d; ovf_q <= ovf_d; start_q <= start_d;
      first_q <= first_d;
      res_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      sentence_kind_o <= kind_q;
      field_index_o   <= 6'(cnt_q);
      field_value_o   <= val[VALUE_BITS-1:0];
      frac_digits_o   <= (status == ST_OK || status == ST_OVERFLOW) ? 3'(frac_q) : 3'd0;
      first_char_o    <= first_q;
      field_status_o  <= status;
      last_field_o    <= last;
    end
  end
endmodule

>>> design/nfp_fifo.sv
module nfp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic             full_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + AW'(1);
      if (do_pop)  rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end
endmodule

>>> design/nmea_field_number_parser.sv
// channel  | handshake    | words
// input    | push / full  | in_byte_i
// result   | pop / empty  | sentence_kind_o .. last_field_o
// one byte is taken every cycle while full is low; a field's closing byte
// is classified in the front stage, evaluated in the back stage and then
// written to the queue; its result shows on the ports when it reaches the head
// reset clears the sentence state; no result is pending after it
// full rises once the queued results plus the words still in the two stages
// reach seven, so an undrained queue stalls the input and never overflows
module nmea_field_number_parser #(
  parameter int unsigned MAX_FRAC_DIGITS = nfp_pkg::MaxFracDigits,
  parameter int unsigned VALUE_BITS      = nfp_pkg::ValueBits,
  parameter int unsigned MAX_FIELDS      = nfp_pkg::MaxFields
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            in_byte_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            sentence_kind_o,
  output logic [5:0]            field_index_o,
  output logic [VALUE_BITS-1:0] field_value_o,
  output logic [2:0]            frac_digits_o,
  output logic [7:0]            first_char_o,
  output logic [1:0]            field_status_o,
  output logic                  last_field_o
);
  import nfp_pkg::*;

  localparam int unsigned ResW  = 2 + 6 + VALUE_BITS + 3 + 8 + 2 + 1;
  localparam int unsigned Depth = 8;

  logic            fe_valid, be_valid, q_empty, q_full;
  token_t          tok;
  logic [ResW-1:0] res_d, res_q;
  logic [1:0]      kind;
  logic [5:0]      idx;
  logic [VALUE_BITS-1:0] val;
  logic [2:0]      fd;
  logic [7:0]      fc;
  logic [1:0]      st;
  logic            lf;
  logic [3:0]      used;

  // two words may be in the front and back stages, so hold back early
  assign used = {3'b000, fe_valid} + {3'b000, be_valid};
  nfp_fifo #(.WIDTH(ResW), .DEPTH(Depth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i (be_valid), .data_i (res_d),
    .pop_i  (pop), .empty_o (q_empty), .full_o (q_full), .data_o (res_q)
  );

  logic [3:0] q_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= '0;
    end else begin
      q_cnt_q <= q_cnt_q + {3'b000, be_valid} - {3'b000, pop && !q_empty};
    end
  end

  assign full  = (q_cnt_q + used) >= 4'(Depth - 1) || q_full;
  assign empty = q_empty;

  nfp_front u_front (
    .clk_i, .rst_ni,
    .valid_i (push && !full), .byte_i (in_byte_i),
    .valid_o (fe_valid), .tok_o (tok)
  );

  nfp_back #(
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
    .VALUE_BITS      (VALUE_BITS),
    .MAX_FIELDS      (MAX_FIELDS)
  ) u_back (
    .clk_i, .rst_ni,
    .valid_i (fe_valid), .tok_i (tok),
    .res_valid_o     (be_valid),
    .sentence_kind_o (kind), .field_index_o (idx), .field_value_o (val),
    .frac_digits_o   (fd), .first_char_o (fc), .field_status_o (st),
    .last_field_o    (lf)
  );

  assign res_d = {kind, idx, val, fd, fc, st, lf};
  assign {sentence_kind_o, field_index_o, field_value_o, frac_digits_o,
          first_char_o, field_status_o, last_field_o} = res_q;
endmodule

>>> test/nmea_field_number_parser_check.sv
`timescale 1ns / 100ps

module nmea_field_number_parser_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  sentence_kind_o,
  input  logic [5:0]  field_index_o,
  input  logic [31:0] field_value_o,
  input  logic [2:0]  frac_digits_o,
  input  logic [7:0]  first_char_o,
  input  logic [1:0]  field_status_o,
  input  logic        last_field_o,
  output int          fail_count_o,
  output int          pending_o,
  output int          words_seen_o,
  output int          status_seen_o [4]
);
  import nfp_pkg::*;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChPoint  = 8'h2e;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowZ   = 8'h7a;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  index;
    logic [31:0] value;
    logic [2:0]  frac;
    logic [7:0]  first;
    status_e     status;
    logic        last;
  } field_word_t;

  field_word_t field_words_due [$];

  // sentence state of the predictor
  logic        in_sent;
  logic [2:0]  hdr_pos;
  logic [1:0]  hdr_match;
  kind_e       kind;
  int unsigned commas;
  logic [63:0] mag;
  logic [2:0]  frac_n;
  logic        neg, seen_point, bad, ovf, started;
  logic [7:0]  first;

  function automatic logic [7:0] chc_char(input int p);
    logic [7:0] s [5];
    s = '{8'h47, 8'h50, 8'h43, 8'h48, 8'h43};
    return s[p];
  endfunction

  function automatic logic [7:0] gga_char(input int p);
    logic [7:0] s [5];
    s = '{8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
    return s[p];
  endfunction

  function automatic logic [63:0] bound_now();
    return neg ? 64'h8000_0000 : 64'h7fff_ffff;
  endfunction

  function automatic void clear_field();
    mag = '0; frac_n = '0; neg = 0; seen_point = 0; bad = 0; ovf = 0;
    started = 0; first = '0;
  endfunction

  function automatic void queue_field(input status_e st, input logic last);
    field_word_t w;
    logic [63:0] m;
    logic [2:0]  f;
    m = '0;
    f = '0;
    if (st == ST_OK) begin
      m = mag; f = frac_n;
    end else if (st == ST_OVERFLOW) begin
      m = bound_now(); f = frac_n;
    end
    w.kind   = kind;
    w.index  = commas[5:0];
    w.value  = neg ? 32'(-m) : m[31:0];
    w.frac   = f;
    w.first  = first;
    w.status = st;
    w.last   = last;
    field_words_due.push_back(w);
  endfunction

  function automatic void take_digit(input logic [63:0] d);
    if (bad || ovf) return;
    if (seen_point && frac_n >= MaxFracDigits) return;
    if (mag > (bound_now() - d) / 10) begin
      ovf = 1;
      return;
    end
    mag = mag * 10 + d;
    if (seen_point) frac_n++;
  endfunction

  function automatic void parse_byte(input logic [7:0] c);
    logic lead;
    if (c == ChDollar) begin
      in_sent = 1; hdr_pos = '0; hdr_match = 2'b11; kind = KIND_OTHER; commas = 0;
      clear_field();
      return;
    end
    if (!in_sent) return;
    if (c < 8'h20 || c > ChLowZ) begin
      if (commas != 0) queue_field(ST_ABORT, 1'b1);
      in_sent = 0;
      return;
    end
    if (commas == 0) begin
      if (c == ChStar) begin
        in_sent = 0;
      end else if (c == ChComma) begin
        if (hdr_pos == HdrLen && hdr_match[0]) kind = KIND_CHC;
        else if (hdr_pos == HdrLen && hdr_match[1]) kind = KIND_GGA;
        else kind = KIND_OTHER;
        commas = 1;
        clear_field();
      end else if (hdr_pos < HdrLen) begin
        if (c != chc_char(hdr_pos)) hdr_match[0] = 0;
        if (c != gga_char(hdr_pos)) hdr_match[1] = 0;
        hdr_pos++;
      end else begin
        hdr_match = '0;
      end
      return;
    end
    if (c == ChComma || c == ChStar) begin
      queue_field(bad ? ST_NOT_NUM : (ovf ? ST_OVERFLOW : ST_OK), c == ChStar);
      if (c == ChStar) in_sent = 0;
      else if (commas < MaxFields) commas++;
      clear_field();
      return;
    end
    lead = !started;
    if (lead) begin
      first = c; started = 1;
    end
    if (c == ChMinus && lead) neg = 1;
    else if (c == ChPoint) begin
      if (seen_point) bad = 1;
      else seen_point = 1;
    end else if (c >= ChZero && c <= ChNine) take_digit(64'(c - ChZero));
    else bad = 1;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    words_seen_o = 0;
    pending_o = 0;
    foreach (status_seen_o[i]) status_seen_o[i] = 0;
    in_sent = 0; hdr_pos = '0; hdr_match = 2'b11; kind = KIND_OTHER; commas = 0;
    clear_field();
  end

  always @(posedge clk_i) begin
    field_word_t w;
    if (rst_ni && push && !full) parse_byte(in_byte_i);
    if (rst_ni && pop && !empty) begin
      words_seen_o++;
      if (field_words_due.size() == 0) begin
        report("unexpected word", 32'(field_index_o), '0);
      end else begin
        w = field_words_due.pop_front();
        status_seen_o[w.status]++;
        if (sentence_kind_o != w.kind)
          report("sentence_kind", 32'(sentence_kind_o), 32'(w.kind));
        if (field_index_o != w.index)
          report("field_index", 32'(field_index_o), 32'(w.index));
        if (field_value_o != w.value) report("field_value", field_value_o, w.value);
        if (frac_digits_o != w.frac)
          report("frac_digits", 32'(frac_digits_o), 32'(w.frac));
        if (first_char_o != w.first)
          report("first_char", 32'(first_char_o), 32'(w.first));
        if (field_status_o != w.status)
          report("field_status", 32'(field_status_o), 32'(w.status));
        if (last_field_o != w.last)
          report("last_field", 32'(last_field_o), 32'(w.last));
      end
    end
    pending_o = field_words_due.size();
  end

endmodule

>>> test/nmea_field_number_parser_test.sv
`timescale 1ns / 100ps

module nmea_field_number_parser_test;
  import nfp_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        push = 0;
  logic        full;
  logic [7:0]  in_byte_i = '0;
  logic        empty;
  logic        pop = 0;
  logic [1:0]  sentence_kind_o;
  logic [5:0]  field_index_o;
  logic [31:0] field_value_o;
  logic [2:0]  frac_digits_o;
  logic [7:0]  first_char_o;
  logic [1:0]  field_status_o;
  logic        last_field_o;
  int          fail_count, pending, words_seen;
  int          status_seen [4];
  int          bytes_sent = 0;
  logic        burst = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  nmea_field_number_parser dut (.*);

  nmea_field_number_parser_check check (
    .*, .fail_count_o(fail_count), .pending_o(pending), .words_seen_o(words_seen),
    .status_seen_o(status_seen)
  );

  task automatic send_byte(input logic [7:0] b);
    int   gap;
    logic ok;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1;
    in_byte_i <= b;
    // full only moves at the rising edge, so look at it mid cycle
    do begin
      @(negedge clk_i);
      ok = !full;
      @(posedge clk_i);
    end while (!ok);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_byte(8'h30 + 8'($urandom_range(0, 9)));
  endtask

  // one data field, mostly well formed numbers
  task automatic send_field();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) return;
    if (pick < 4) begin
      send_byte(8'($urandom_range(8'h41, 8'h5a)));
      return;
    end
    if ($urandom_range(0, 2) == 0) send_text("-");
    if (pick == 4) send_digits($urandom_range(10, 14));
    else send_digits($urandom_range(0, 6));
    if ($urandom_range(0, 2) != 0) begin
      send_text(".");
      send_digits($urandom_range(0, 8));
    end
    case (pick)
      5: send_text(".");
      6: send_text("-");
      7: send_byte(8'($urandom_range(8'h20, 8'h7a)));
      default: ;
    endcase
    if (pick == 7) send_digits($urandom_range(0, 2));
  endtask

  task automatic send_sentence();
    int nf;
    send_text("$");
    case ($urandom_range(0, 5))
      0, 1: send_text("GPCHC");
      2, 3: send_text("GPGGA");
      4: send_text("GPGG");
      default: repeat ($urandom_range(0, 7)) send_byte(8'($urandom_range(8'h20, 8'h7a)));
    endcase
    if ($urandom_range(0, 29) == 0) begin
      send_text("*");
      return;
    end
    nf = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
    for (int i = 0; i < nf; i++) begin
      send_text(",");
      send_field();
      if ($urandom_range(0, 59) == 0) begin
        // abort mid field with a control byte or a byte above 0x7a
        if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 8'h1f)));
        else send_byte(8'($urandom_range(8'h7b, 8'hff)));
        return;
      end
      if ($urandom_range(0, 99) == 0) begin
        send_text("$");
        return;
      end
    end
    send_text("*");
    send_byte(8'h30 + 8'($urandom_range(0, 9)));
    send_byte(8'h41 + 8'($urandom_range(0, 5)));
    send_byte(8'h0d);
    send_byte(8'h0a);
  endtask

  initial begin
    int   stall;
    logic ok;
    wait (rst_ni);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        pop <= 0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1;
      do begin
        @(negedge clk_i);
        ok = !empty;
        @(posedge clk_i);
      end while (!ok);
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: both headers, overflow, lone minus, point-first, bad char, aborts
    send_text("$GPGGA,9999999999,-,.5A,*");
    send_text("$GPCHC,-2147483648,-1.234567,,1..2");
    send_byte(8'hff);
    send_text("$X,1");
    send_byte(8'h00);
    for (int seg = 0; bytes_sent < 950; seg++) begin
      burst = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)));
      send_sentence();
      if (seg == 10) begin
        push <= 0;
        while (pending != 0) @(posedge clk_i);
        repeat (20) @(posedge clk_i);
      end
    end
    push <= 0;
    burst = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d bytes, checked %0d field words", bytes_sent, words_seen);
    $display("status mix ok/not-num/overflow/abort: %0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS nmea_field_number_parser");
    end else begin
      $display("FAIL nmea_field_number_parser");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL nmea_field_number_parser");
    $finish;
  end

endmodule

>>> files.f
design/nfp_pkg.sv
design/nfp_front.sv
design/nfp_back.sv
design/nfp_fifo.sv
design/nmea_field_number_parser.sv
test/nmea_field_number_parser_check.sv
test/nmea_field_number_parser_test.sv
